// ----- sv/bmp_psp_pkg.sv -----
// Shared types and constants of the BMP pixel stream parser.
// No dependencies; compiled first.
package bmp_psp_pkg;

   localparam int FILE_HDR_BYTES     = 14;
   localparam int INFO_HDR_BYTES_DEF = 40;
   localparam int DIM_BITS_DEF       = 16;

   localparam logic [7:0] MAGIC_B = 8'h42;
   localparam logic [7:0] MAGIC_M = 8'h4D;

   // Byte offsets of the little-endian width and height words in the header.
   localparam int WIDTH_OFS  = FILE_HDR_BYTES + 4;
   localparam int HEIGHT_OFS = FILE_HDR_BYTES + 8;

   typedef enum logic [1:0] {
      KIND_HEADER    = 2'd0,
      KIND_PIXEL     = 2'd1,
      KIND_BAD_MAGIC = 2'd2,
      KIND_BAD_SIZE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PIXEL  = 2'd1,
      PH_PAD    = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] column;
      logic [15:0] row;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        last_pixel;
   } result_type;

endpackage

// ----- sv/bmp_psp_if.sv -----
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on bmp_psp_pkg.
interface bmp_psp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       file_start;

   modport source (output valid, output data_byte, output file_start, input ready);
   modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface bmp_psp_rsp_if;
   logic                  valid;
   logic                  ready;
   bmp_psp_pkg::kind_type result_kind;
   logic [7:0]            red;
   logic [7:0]            green;
   logic [7:0]            blue;
   logic [15:0]           column;
   logic [15:0]           row;
   logic [15:0]           image_width;
   logic [15:0]           image_height;
   logic                  last_pixel;

   modport source (output valid, output result_kind, output red, output green,
                   output blue, output column, output row, output image_width,
                   output image_height, output last_pixel, input ready);
   modport sink   (input valid, input result_kind, input red, input green,
                   input blue, input column, input row, input image_width,
                   input image_height, input last_pixel, output ready);
endinterface

// ----- sv/bmp_psp_core.sv -----
// Parse state of the BMP reader: header counting, size capture, pixel and
// padding tracking. Depends on bmp_psp_pkg.
module bmp_psp_core #(
   parameter int DIM_BITS       = bmp_psp_pkg::DIM_BITS_DEF,
   parameter int INFO_HDR_BYTES = bmp_psp_pkg::INFO_HDR_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [7:0]              data_byte,
   input  logic                    file_start,
   output logic                    res_valid,
   output bmp_psp_pkg::result_type res
);
   import bmp_psp_pkg::*;

   localparam int HDR_TOTAL = FILE_HDR_BYTES + INFO_HDR_BYTES;
   localparam int HC_BITS   = $clog2(HDR_TOTAL);

   phase_type            phase_ff, phase_in, cur_phase;
   logic [HC_BITS-1:0]   hc_ff, hc_in, cur_hc;
   logic                 magic_ff, magic_in;
   logic [31:0]          width_ff, width_in;
   logic [31:0]          height_ff, height_in;
   logic [1:0]           chan_ff, chan_in;
   logic [7:0]           blue_ff, blue_in;
   logic [7:0]           green_ff, green_in;
   logic [DIM_BITS-1:0]  col_ff, col_in;
   logic [DIM_BITS-1:0]  row_ff, row_in;
   logic [1:0]           pad_ff, pad_in;

   logic [DIM_BITS-1:0]  col_next, row_next;
   logic                 row_end, img_end;
   logic [31:0]          col_ext, row_ext;

   function automatic logic size_bad(input logic [31:0] v);
      return v[31] || ((v >> DIM_BITS) != 32'd0);
   endfunction

   assign col_next = col_ff + DIM_BITS'(1);
   assign row_next = row_ff + DIM_BITS'(1);
   // Sizes are within the bound once pixels flow, so the low bits compare exactly.
   assign row_end  = (col_next == width_ff[DIM_BITS-1:0]);
   assign img_end  = row_end && (row_next == height_ff[DIM_BITS-1:0]);
   assign col_ext  = 32'(col_ff);
   assign row_ext  = 32'(row_ff);

   always_comb begin
      cur_phase = file_start ? PH_HEADER : phase_ff;
      cur_hc    = file_start ? '0 : hc_ff;
      phase_in  = cur_phase;
      hc_in     = cur_hc;
      magic_in  = magic_ff;
      width_in  = width_ff;
      height_in = height_ff;
      chan_in   = chan_ff;
      blue_in   = blue_ff;
      green_in  = green_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pad_in    = pad_ff;
      res_valid = 1'b0;
      res       = '0;

      case (cur_phase)
         PH_HEADER: begin
            if (cur_hc == '0) begin
               magic_in = (data_byte == MAGIC_B);
            end else if (cur_hc == HC_BITS'(1)) begin
               magic_in = magic_ff && (data_byte == MAGIC_M);
            end
            for (int k = 0; k < 4; k++) begin
               if (cur_hc == HC_BITS'(WIDTH_OFS + k)) width_in[8*k +: 8] = data_byte;
               if (cur_hc == HC_BITS'(HEIGHT_OFS + k)) height_in[8*k +: 8] = data_byte;
            end
            if (cur_hc != HC_BITS'(HDR_TOTAL - 1)) begin
               hc_in = cur_hc + HC_BITS'(1);
            end else begin
               hc_in     = '0;
               res_valid = 1'b1;
               if (!magic_in) begin
                  phase_in        = PH_DONE;
                  res.result_kind = KIND_BAD_MAGIC;
               end else if (size_bad(width_in) || size_bad(height_in)) begin
                  phase_in        = PH_DONE;
                  res.result_kind = KIND_BAD_SIZE;
               end else begin
                  res.result_kind  = KIND_HEADER;
                  res.image_width  = width_in[15:0];
                  res.image_height = height_in[15:0];
                  col_in  = '0;
                  row_in  = '0;
                  chan_in = 2'd0;
                  phase_in = (width_in == 32'd0 || height_in == 32'd0) ? PH_DONE : PH_PIXEL;
               end
            end
         end
         PH_PAD: begin
            pad_in = pad_ff - 2'd1;
            if (pad_ff == 2'd1) phase_in = PH_PIXEL;
         end
         PH_PIXEL: begin
            case (chan_ff)
               2'd0: begin
                  blue_in = data_byte;
                  chan_in = 2'd1;
               end
               2'd1: begin
                  green_in = data_byte;
                  chan_in  = 2'd2;
               end
               default: begin
                  chan_in         = 2'd0;
                  res_valid       = 1'b1;
                  res.result_kind = KIND_PIXEL;
                  res.red         = data_byte;
                  res.green       = green_ff;
                  res.blue        = blue_ff;
                  res.column      = col_ext[15:0];
                  res.row         = row_ext[15:0];
                  res.last_pixel  = img_end;
                  col_in          = col_next;
                  if (row_end) begin
                     col_in = '0;
                     row_in = row_next;
                     if (img_end) begin
                        phase_in = PH_DONE;
                     end else if (width_ff[1:0] != 2'd0) begin
                        // Row padding length equals width mod 4 for 3-byte pixels.
                        pad_in   = width_ff[1:0];
                        phase_in = PH_PAD;
                     end
                  end
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         hc_ff    <= '0;
         chan_ff  <= 2'd0;
         pad_ff   <= 2'd0;
         col_ff   <= '0;
         row_ff   <= '0;
         magic_ff <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         hc_ff    <= hc_in;
         chan_ff  <= chan_in;
         pad_ff   <= pad_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         magic_ff <= magic_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         width_ff  <= width_in;
         height_ff <= height_in;
         blue_ff   <= blue_in;
         green_ff  <= green_in;
      end
   end

endmodule

// ----- sv/bmp_pixel_stream_parser_unit.sv -----
// Top level of the BMP pixel stream parser: input register, parse core and
// result register. Depends on bmp_psp_pkg, bmp_psp_if and bmp_psp_core.
//
// Usage:
//   req_bus carries one byte of a 24-bit uncompressed BMP file per transfer;
//   file_start marks byte 0 of a new file and restarts the parse at once.
//   rsp_bus gives one header result when the header ends (or a bad magic or
//   size error instead), then one pixel result per blue/green/red triple,
//   bottom row first. Padding, trailing bytes and bytes after an error
//   produce no result.
//   Throughput is one byte per cycle while rsp_bus does not stall. A byte
//   that completes a result is held in the input register, and its result
//   then in the result register, which drives rsp_bus.
//   When the receiver stalls, the result register holds its content and the
//   input register keeps one further byte; req_bus.ready drops only while
//   both are full and rsp_bus.ready is low.
//   Reset empties both registers and puts the parser back in the header phase,
//   so a stream without a start mark is still parsed as a file.
module bmp_pixel_stream_parser_unit #(
   parameter int DIM_BITS       = bmp_psp_pkg::DIM_BITS_DEF,
   parameter int INFO_HDR_BYTES = bmp_psp_pkg::INFO_HDR_BYTES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   bmp_psp_req_if.sink    req_bus,
   bmp_psp_rsp_if.source  rsp_bus
);
   import bmp_psp_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       out_valid_ff;
   result_type out_res_ff;

   logic       out_free, advance, res_valid;
   result_type res;

   assign out_free    = !out_valid_ff || rsp_bus.ready;
   assign advance     = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;

   bmp_psp_core #(
      .DIM_BITS       (DIM_BITS),
      .INFO_HDR_BYTES (INFO_HDR_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .data_byte  (in_byte_ff),
      .file_start (in_start_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) in_valid_ff <= req_bus.valid;
         if (out_free) out_valid_ff <= advance && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff  <= req_bus.data_byte;
         in_start_ff <= req_bus.file_start;
      end
      if (advance && res_valid) out_res_ff <= res;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.result_kind  = out_res_ff.result_kind;
   assign rsp_bus.red          = out_res_ff.red;
   assign rsp_bus.green        = out_res_ff.green;
   assign rsp_bus.blue         = out_res_ff.blue;
   assign rsp_bus.column       = out_res_ff.column;
   assign rsp_bus.row          = out_res_ff.row;
   assign rsp_bus.image_width  = out_res_ff.image_width;
   assign rsp_bus.image_height = out_res_ff.image_height;
   assign rsp_bus.last_pixel   = out_res_ff.last_pixel;

endmodule
